>>> rtl/omw_pkg.sv
// Shared types and constants of the omni wheel drive mixer.
// Used by every module under rtl; depends on nothing else.
package omw_pkg;

    localparam int LANES              = 4;
    localparam int LANE_W             = 16;
    localparam int SPEED_W            = 8;
    localparam int EFFORT_W           = 9;
    localparam int MODE_W             = 2;
    localparam int DUTY_W             = 8;
    localparam int BUDGET_W           = 11;
    localparam int QUOT_W             = 10;
    localparam int SINE_LAT           = 4;

    localparam int DEF_ANGLE_BITS     = 12;
    localparam int DEF_COEF_FRAC_BITS = 14;
    localparam int DEF_DUTY_MAX       = 255;

    localparam int CFG_ADDR_W         = 5;
    localparam int CFG_DATA_W         = 64;

    localparam logic [16:0] Q15_ONE   = 17'd32768;
    localparam logic [15:0] POLY_A    = 16'd51437;
    localparam logic [15:0] POLY_B    = 16'd20953;
    localparam logic [15:0] POLY_C    = 16'd2284;

    localparam logic [MODE_W-1:0] MODE_NO_Y = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NO_X = 2'd2;

    localparam logic [1:0] REG_SIN_COEFS = 2'd0;
    localparam logic [1:0] REG_COS_COEFS = 2'd1;
    localparam logic [1:0] REG_MOTOR_DIS = 2'd2;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] sin_coefs;
        logic [CFG_DATA_W-1:0] cos_coefs;
        logic                  motor_disable;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic zero_norm;
    } t_tag;

endpackage

>>> rtl/omw_regs.sv
// Configuration register file with an APB-style write/read port.
// Depends on omw_pkg.
module omw_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [omw_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [omw_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [omw_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output omw_pkg::t_cfg                   o_cfg
);
    import omw_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] idx;
    logic       wr;

    assign idx    = paddr[CFG_ADDR_W-1:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            case (idx)
                REG_SIN_COEFS: r_cfg.sin_coefs     <= pwdata;
                REG_COS_COEFS: r_cfg.cos_coefs     <= pwdata;
                REG_MOTOR_DIS: r_cfg.motor_disable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SIN_COEFS: prdata = r_cfg.sin_coefs;
            REG_COS_COEFS: prdata = r_cfg.cos_coefs;
            REG_MOTOR_DIS: prdata = {{(CFG_DATA_W-1){1'b0}}, r_cfg.motor_disable};
            default:       prdata = '0;
        endcase
    end

endmodule

>>> rtl/omw_sine.sv
// Four-stage pipelined quarter-wave polynomial sine of a binary angle.
// Depends on omw_pkg for the polynomial constants.
module omw_sine #(
    parameter int ANGLE_BITS     = omw_pkg::DEF_ANGLE_BITS,
    parameter int COEF_FRAC_BITS = omw_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [ANGLE_BITS-1:0]            i_angle,
    output logic signed [COEF_FRAC_BITS+1:0] o_val
);
    import omw_pkg::*;

    localparam int QB = ANGLE_BITS - 2;
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int XW = 17;
    localparam int YW = 18;

    logic [1:0]        quad;
    logic [XW-1:0]     x_lin, x0;
    logic [2*XW-1:0]   sq;
    logic [32:0]       cp, tp, yp;
    logic [YW-1:0]     y;
    logic [CW-2:0]     mag;

    logic [XW-1:0]     r1_x, r1_x2, r2_x, r2_x2, r3_x;
    logic [15:0]       r2_t, r3_t;
    logic [1:0]        r1_quad, r2_quad, r3_quad;
    logic signed [CW-1:0] r4_val;

    assign quad  = i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
    assign x_lin = XW'(i_angle[QB-1:0]) << (XW - ANGLE_BITS);
    assign x0    = quad[0] ? (Q15_ONE - x_lin) : x_lin;
    assign sq    = x0 * x0;
    assign cp    = 33'(POLY_C) * 33'(r1_x2);
    assign tp    = 33'(r2_t) * 33'(r2_x2);
    assign yp    = 33'(r3_t) * 33'(r3_x);
    assign y     = yp[15 +: YW];

    generate
        if (COEF_FRAC_BITS >= 15) begin : g_up
            logic [YW+COEF_FRAC_BITS-15-1:0] ys;
            assign ys  = (YW+COEF_FRAC_BITS-15)'(y) << (COEF_FRAC_BITS - 15);
            assign mag = ys[CW-2:0];
        end else begin : g_dn
            logic [YW-1:0] ys;
            assign ys  = y >> (15 - COEF_FRAC_BITS);
            assign mag = ys[CW-2:0];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x    <= x0;
            r1_x2   <= sq[15 +: XW];
            r1_quad <= quad;
            r2_t    <= POLY_B - cp[30:15];
            r2_x    <= r1_x;
            r2_x2   <= r1_x2;
            r2_quad <= r1_quad;
            r3_t    <= POLY_A - tp[30:15];
            r3_x    <= r2_x;
            r3_quad <= r2_quad;
            r4_val  <= r3_quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    assign o_val = r4_val;

endmodule

>>> rtl/omw_mix.sv
// Six-stage wheel mixing pipeline: wheel projections, raw mixes, normalizer,
// and the numerator magnitudes with their signs and the divisor for the divider. Depends on omw_pkg.
module omw_mix #(
    parameter int COEF_FRAC_BITS = omw_pkg::DEF_COEF_FRAC_BITS,
    parameter int NW             = COEF_FRAC_BITS + 52
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [COEF_FRAC_BITS+1:0]     i_cx,
    input  logic signed [COEF_FRAC_BITS+1:0]     i_sy,
    input  logic [omw_pkg::SPEED_W-1:0]          i_speed,
    input  logic signed [omw_pkg::EFFORT_W-1:0]  i_effort,
    input  logic [omw_pkg::MODE_W-1:0]           i_mode,
    input  omw_pkg::t_cfg                        i_cfg,
    output omw_pkg::t_tag                        o_tag,
    output logic [NW-1:0]                        o_num [omw_pkg::LANES],
    output logic [omw_pkg::LANES-1:0]            o_neg,
    output logic [NW-1:0]                        o_den
);
    import omw_pkg::*;

    localparam int CW  = COEF_FRAC_BITS + 2;
    localparam int PW  = LANE_W + CW + 1;
    localparam int MW  = PW + BUDGET_W + 1;
    localparam int MBW = MW + BUDGET_W;
    localparam int EHW = EFFORT_W + MW + 1;

    logic signed [CW-1:0]       cxe, sye;
    logic signed [BUDGET_W-1:0] bud_in;

    logic [5:0] r_vld;

    logic signed [PW-1:0]       r1_p [LANES];
    logic signed [BUDGET_W-1:0] r1_bud, r2_bud;
    logic signed [EFFORT_W-1:0] r1_eff, r2_eff, r3_eff, r4_eff, r5_eff;
    logic signed [MW-1:0]       r2_m [LANES];
    logic signed [MBW-1:0]      r3_mb [LANES];
    logic [MW-1:0]              r3_a [LANES];
    logic signed [NW-1:0]       r4_mb10 [LANES];
    logic [MW-1:0]              r4_h, r5_h;
    logic signed [NW-1:0]       r5_mb10 [LANES];
    logic signed [EHW-1:0]      r5_eh;
    logic [NW-1:0]              r6_num [LANES];
    logic [LANES-1:0]           r6_neg;
    logic [NW-1:0]              r6_den;
    logic                       r6_zn;

    logic [MW-1:0]        h01, h23, h_all;
    logic signed [NW-1:0] eh13, e13;
    logic signed [NW-1:0] num_sel [LANES];
    logic                 zero_h;

    assign cxe    = (i_mode == MODE_NO_X) ? '0 : i_cx;
    assign sye    = (i_mode == MODE_NO_Y) ? '0 : i_sy;
    assign bud_in = $signed({{(BUDGET_W-SPEED_W){1'b0}}, i_speed}) - BUDGET_W'(i_effort);

    assign h01   = (r3_a[0] > r3_a[1]) ? r3_a[0] : r3_a[1];
    assign h23   = (r3_a[2] > r3_a[3]) ? r3_a[2] : r3_a[3];
    assign h_all = (h01 > h23) ? h01 : h23;

    assign zero_h = (r5_h == '0);
    assign eh13   = (NW'(r5_eh) <<< 3) + (NW'(r5_eh) <<< 2) + NW'(r5_eh);
    assign e13    = (NW'(r5_eff) <<< 3) + (NW'(r5_eff) <<< 2) + NW'(r5_eff);

    // Wheels 1 and 2 carry the extra turn term; with a zero normalizer only
    // that term is left and the divisor becomes ten.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (zero_h) begin
                num_sel[i] = (i == 1 || i == 2) ? e13 : '0;
            end else begin
                num_sel[i] = (i == 1 || i == 2) ? (r5_mb10[i] + eh13) : r5_mb10[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < LANES; i++) begin
                logic signed [LANE_W-1:0] s_c, c_c;
                s_c = i_cfg.sin_coefs[LANE_W*i +: LANE_W];
                c_c = i_cfg.cos_coefs[LANE_W*i +: LANE_W];
                r1_p[i]    <= PW'(c_c * sye) - PW'(s_c * cxe);
                r2_m[i]    <= MW'(r1_p[i] * r1_bud) + (MW'(r1_eff) <<< (2*COEF_FRAC_BITS));
                r3_mb[i]   <= r2_m[i] * r2_bud;
                r3_a[i]    <= r2_m[i][MW-1] ? MW'(-r2_m[i]) : MW'(r2_m[i]);
                r4_mb10[i] <= (NW'(r3_mb[i]) <<< 3) + (NW'(r3_mb[i]) <<< 1);
                r5_mb10[i] <= r4_mb10[i];
                r6_neg[i]  <= num_sel[i][NW-1];
                r6_num[i]  <= num_sel[i][NW-1] ? NW'(-num_sel[i]) : NW'(num_sel[i]);
            end
            r1_bud <= bud_in;
            r1_eff <= i_effort;
            r2_bud <= r1_bud;
            r2_eff <= r1_eff;
            r3_eff <= r2_eff;
            r4_eff <= r3_eff;
            r4_h   <= h_all;
            r5_eff <= r4_eff;
            r5_h   <= r4_h;
            r5_eh  <= r4_eff * $signed({1'b0, r4_h});
            r6_zn  <= zero_h;
            r6_den <= zero_h ? NW'(10) : ((NW'(r5_h) << 3) + (NW'(r5_h) << 1));
        end
    end

    assign o_tag.valid     = r_vld[5];
    assign o_tag.zero_norm = r6_zn;
    assign o_num           = r6_num;
    assign o_neg           = r6_neg;
    assign o_den           = r6_den;

endmodule

>>> rtl/omw_div.sv
// Restoring divider for the four wheel magnitudes, one quotient bit per stage.
// Depends on omw_pkg.
module omw_div #(
    parameter int NW = 66,
    parameter int QW = omw_pkg::QUOT_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  omw_pkg::t_tag             i_tag,
    input  logic [NW-1:0]             i_num [omw_pkg::LANES],
    input  logic [omw_pkg::LANES-1:0] i_neg,
    input  logic [NW-1:0]             i_den,
    output omw_pkg::t_tag             o_tag,
    output logic [QW-1:0]             o_quot [omw_pkg::LANES],
    output logic [omw_pkg::LANES-1:0] o_neg
);
    import omw_pkg::*;

    logic [NW-1:0]    r_rem [QW][LANES];
    logic [QW-1:0]    r_q   [QW][LANES];
    logic [NW-1:0]    r_den [QW];
    logic [LANES-1:0] r_neg [QW];
    t_tag             r_tag [QW];

    // Every quotient is known to fit in QW bits, so the remainder entering
    // the stage for bit b is always below the divisor shifted up by b+1.
    generate
        for (genvar k = 0; k < QW; k++) begin : g_stage
            localparam int B = QW - 1 - k;
            logic [NW-1:0]    rem_in [LANES];
            logic [QW-1:0]    q_in   [LANES];
            logic [NW-1:0]    den_in;
            logic [LANES-1:0] neg_in;
            t_tag             tag_in;
            logic [NW+QW-1:0] dsh;

            if (k == 0) begin : g_first
                assign rem_in = i_num;
                assign den_in = i_den;
                assign neg_in = i_neg;
                assign tag_in = i_tag;
                always_comb begin
                    for (int i = 0; i < LANES; i++) q_in[i] = '0;
                end
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign q_in   = r_q[k-1];
                assign den_in = r_den[k-1];
                assign neg_in = r_neg[k-1];
                assign tag_in = r_tag[k-1];
            end

            assign dsh = (NW+QW)'(den_in) << B;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_tag[k] <= '0;
                end else if (i_en) begin
                    r_tag[k] <= tag_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int i = 0; i < LANES; i++) begin
                        if ((NW+QW)'(rem_in[i]) >= dsh) begin
                            r_rem[k][i]  <= NW'((NW+QW)'(rem_in[i]) - dsh);
                            r_q[k][i]    <= q_in[i] | (QW'(1) << B);
                        end else begin
                            r_rem[k][i]  <= rem_in[i];
                            r_q[k][i]    <= q_in[i];
                        end
                    end
                    r_den[k] <= den_in;
                    r_neg[k] <= neg_in;
                end
            end
        end
    endgenerate

    assign o_tag  = r_tag[QW-1];
    assign o_quot = r_q[QW-1];
    assign o_neg  = r_neg[QW-1];

endmodule

>>> rtl/omw_ctl_placeholder.sv
// Output stage: clamp, motor disable and split of each drive into H-bridge duties.
// Depends on omw_pkg.
module omw_out #(
    parameter int DUTY_MAX = omw_pkg::DEF_DUTY_MAX
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  omw_pkg::t_tag                              i_tag,
    input  logic [omw_pkg::QUOT_W-1:0]                 i_quot [omw_pkg::LANES],
    input  logic [omw_pkg::LANES-1:0]                  i_neg,
    input  logic                                       i_motor_disable,
    output logic                                       o_valid,
    output logic [2*omw_pkg::DUTY_W*omw_pkg::LANES-1:0] o_data,
    output logic                                       o_zero_norm
);
    import omw_pkg::*;

    localparam int DMW  = $clog2(DUTY_MAX + 1);
    localparam int CMPW = (QUOT_W > DMW) ? QUOT_W : DMW;

    logic                           r_valid;
    logic [2*DUTY_W*LANES-1:0]      r_data;
    logic                           r_zn;
    logic [2*DUTY_W*LANES-1:0]      n_data;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            logic [CMPW-1:0]   mag;
            logic [DUTY_W-1:0] duty;
            mag  = (CMPW'(i_quot[i]) > CMPW'(DUTY_MAX)) ? CMPW'(DUTY_MAX) : CMPW'(i_quot[i]);
            duty = i_motor_disable ? '0 : mag[DUTY_W-1:0];
            n_data[2*DUTY_W*i +: DUTY_W]        = i_neg[i] ? '0 : duty;
            n_data[2*DUTY_W*i+DUTY_W +: DUTY_W] = i_neg[i] ? duty : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_zn   <= i_tag.zero_norm;
        end
    end

    assign o_valid     = r_valid;
    assign o_data      = r_data;
    assign o_zero_norm = r_zn;

endmodule

>>> rtl/omni_wheel_drive_mixer.sv
// Top level of the four-wheel omni drive mixer: stream ports, register port,
// sine pipelines, mixer, divider and output stage. Depends on omw_pkg and all rtl modules.
//
//   channel    handshake                  payload
//   s_axis     s_axis_tvalid/tready       tdata heading|speed|turn_effort, tuser axis_mode
//   m_axis     m_axis_tvalid/tready       tdata fwd/rev duties, tuser zero_norm
//   apb        psel/penable/pready        paddr, pwdata, prdata (64-bit registers)
//
// One beat is taken every cycle while the output is not stalled; a result passes through
// 4 sine stages, 6 mixer stages, 10 divider stages and 1 output register.
// The ten-stage restoring divider is the deepest part; throughput is one beat per cycle unless stalled.
// Reset clears the valid bits and the configuration registers; no clearing pass is needed.
// A stalled output freezes the whole pipeline, so nothing is dropped or repeated.
module omni_wheel_drive_mixer #(
    parameter int ANGLE_BITS     = omw_pkg::DEF_ANGLE_BITS,
    parameter int COEF_FRAC_BITS = omw_pkg::DEF_COEF_FRAC_BITS,
    parameter int DUTY_MAX       = omw_pkg::DEF_DUTY_MAX,
    parameter int IN_TW          = ((ANGLE_BITS + omw_pkg::SPEED_W + omw_pkg::EFFORT_W + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // heading, speed, turn_effort from the lowest bit up, zero filled
    input  logic [IN_TW-1:0]                   s_axis_tdata,
    // axis_mode
    input  logic [omw_pkg::MODE_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // fwd_duty_0, rev_duty_0, fwd_duty_1, rev_duty_1, ... rev_duty_3 from the lowest bit up
    output logic [2*omw_pkg::DUTY_W*omw_pkg::LANES-1:0] m_axis_tdata,
    // zero_norm
    output logic                               m_axis_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [omw_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [omw_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [omw_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import omw_pkg::*;

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int NW = COEF_FRAC_BITS + 52;

    t_cfg cfg;
    logic en;

    logic [ANGLE_BITS-1:0]      heading, heading_cos;
    logic [SPEED_W-1:0]         speed;
    logic signed [EFFORT_W-1:0] effort;

    logic signed [CW-1:0] cx, sy;

    logic                       r_sd_vld   [SINE_LAT];
    logic [SPEED_W-1:0]         r_sd_speed [SINE_LAT];
    logic signed [EFFORT_W-1:0] r_sd_eff   [SINE_LAT];
    logic [MODE_W-1:0]          r_sd_mode  [SINE_LAT];

    t_tag             mix_tag, div_tag;
    logic [NW-1:0]    mix_num [LANES];
    logic [LANES-1:0] mix_neg, div_neg;
    logic [NW-1:0]    mix_den;
    logic [QUOT_W-1:0] div_quot [LANES];

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    assign heading     = s_axis_tdata[ANGLE_BITS-1:0];
    assign speed       = s_axis_tdata[ANGLE_BITS +: SPEED_W];
    assign effort      = s_axis_tdata[ANGLE_BITS+SPEED_W +: EFFORT_W];
    assign heading_cos = heading + (ANGLE_BITS'(1) << (ANGLE_BITS - 2));

    omw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    omw_sine #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_cos (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (heading_cos),
        .o_val   (cx)
    );

    omw_sine #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sin (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (heading),
        .o_val   (sy)
    );

    // Side channel that keeps speed, effort and mode in step with the sine pipelines.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SINE_LAT; k++) r_sd_vld[k] <= 1'b0;
        end else if (en) begin
            r_sd_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < SINE_LAT; k++) r_sd_vld[k] <= r_sd_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd_speed[0] <= speed;
            r_sd_eff[0]   <= effort;
            r_sd_mode[0]  <= s_axis_tuser;
            for (int k = 1; k < SINE_LAT; k++) begin
                r_sd_speed[k] <= r_sd_speed[k-1];
                r_sd_eff[k]   <= r_sd_eff[k-1];
                r_sd_mode[k]  <= r_sd_mode[k-1];
            end
        end
    end

    omw_mix #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .NW(NW)) u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_sd_vld[SINE_LAT-1]),
        .i_cx     (cx),
        .i_sy     (sy),
        .i_speed  (r_sd_speed[SINE_LAT-1]),
        .i_effort (r_sd_eff[SINE_LAT-1]),
        .i_mode   (r_sd_mode[SINE_LAT-1]),
        .i_cfg    (cfg),
        .o_tag    (mix_tag),
        .o_num    (mix_num),
        .o_neg    (mix_neg),
        .o_den    (mix_den)
    );

    omw_div #(.NW(NW), .QW(QUOT_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (mix_tag),
        .i_num   (mix_num),
        .i_neg   (mix_neg),
        .i_den   (mix_den),
        .o_tag   (div_tag),
        .o_quot  (div_quot),
        .o_neg   (div_neg)
    );

    omw_out #(.DUTY_MAX(DUTY_MAX)) u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_tag           (div_tag),
        .i_quot          (div_quot),
        .i_neg           (div_neg),
        .i_motor_disable (cfg.motor_disable),
        .o_valid         (m_axis_tvalid),
        .o_data          (m_axis_tdata),
        .o_zero_norm     (m_axis_tuser)
    );

endmodule

>>> tb/omni_wheel_drive_mixer_tb.sv
// Self-checking testbench of the omni wheel drive mixer: a directed table, then random beats
// under several register settings and idling patterns. Depends on omw_pkg and the rtl top.
module omni_wheel_drive_mixer_tb;
    import omw_pkg::*;

    typedef struct {
        logic [63:0] duties;
        logic        zero_norm;
    } t_drive;

    typedef struct {
        int          step;
        logic [11:0] heading;
        logic [7:0]  speed;
        logic [8:0]  effort;
        logic [1:0]  mode;
        bit          typed;
        logic [63:0] duties;
        logic        zero_norm;
    } t_row;

    localparam logic [4:0] ADDR_SIN = 5'(8 * REG_SIN_COEFS);
    localparam logic [4:0] ADDR_COS = 5'(8 * REG_COS_COEFS);
    localparam logic [4:0] ADDR_DIS = 5'(8 * REG_MOTOR_DIS);
    // Mount angles 45, 135, 225 and 315 degrees in Q2.14.
    localparam logic [63:0] OMNI_SIN = {16'hD2BF, 16'hD2BF, 16'h2D41, 16'h2D41};
    localparam logic [63:0] OMNI_COS = {16'h2D41, 16'hD2BF, 16'hD2BF, 16'h2D41};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    // Shadow of the register file, used by the predictor.
    logic [63:0] sin_coefs = '0;
    logic [63:0] cos_coefs = '0;
    logic        disabled = 1'b0;

    t_drive drive_q[$];
    int     mismatches = 0;
    int     idle_mode = 0;      // 0 none, 1 sender, 2 receiver, 3 both
    int     hold_cnt = 0;

    omni_wheel_drive_mixer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Quarter-wave polynomial sine, Q2.14 result.
    function automatic longint heading_sine(int unsigned ang);
        int unsigned a;
        int unsigned quad;
        longint x;
        longint x2;
        longint t;
        longint y;
        a = ang & 32'hFFF;
        quad = (a >> 10) & 3;
        x = longint'(a & 32'h3FF) << 5;
        if (quad[0]) x = 32768 - x;
        x2 = (x * x) >>> 15;
        t = (2284 * x2) >>> 15;
        t = 20953 - t;
        t = (t * x2) >>> 15;
        t = 51437 - t;
        y = (t * x) >>> 15;
        y = y / 2;
        if (quad[1]) y = -y;
        return y;
    endfunction

    function automatic t_drive wheel_drive(logic [11:0] heading, logic [7:0] speed,
                                           logic [8:0] effort_raw, logic [1:0] mode);
        t_drive r;
        longint cx;
        longint sy;
        longint effort;
        longint budget;
        longint h;
        longint p;
        longint v;
        longint mix[4];
        cx = heading_sine(heading + 1024);
        sy = heading_sine(heading);
        effort = longint'($signed(effort_raw));
        if (mode == MODE_NO_Y) sy = 0;
        else if (mode == MODE_NO_X) cx = 0;
        budget = longint'(speed) - effort;
        h = 0;
        for (int i = 0; i < 4; i++) begin
            p = -longint'($signed(sin_coefs[16*i +: 16])) * cx
                + longint'($signed(cos_coefs[16*i +: 16])) * sy;
            mix[i] = p * budget + (effort <<< 28);
            if (mix[i] > h) h = mix[i];
            if (-mix[i] > h) h = -mix[i];
        end
        r.duties = '0;
        for (int i = 0; i < 4; i++) begin
            if (h == 0) begin
                v = (i == 1 || i == 2) ? (13 * effort) / 10 : 0;
            end else begin
                v = mix[i] * budget * 10;
                if (i == 1 || i == 2) v += 13 * effort * h;
                v = v / (10 * h);
            end
            if (disabled) v = 0;
            if (v > 255) v = 255;
            else if (v < -255) v = -255;
            if (v > 0) r.duties[16*i +: 8] = v[7:0];
            else if (v < 0) r.duties[16*i + 8 +: 8] = 8'(-v);
        end
        r.zero_norm = (h == 0);
        return r;
    endfunction

    task automatic reg_write(logic [4:0] addr, logic [63:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SIN) sin_coefs = data;
        else if (addr == ADDR_COS) cos_coefs = data;
        else disabled = data[0];
    endtask

    task automatic set_coefs(logic [63:0] s, logic [63:0] c, logic dis);
        reg_write(ADDR_SIN, s);
        reg_write(ADDR_COS, c);
        reg_write(ADDR_DIS, {63'd0, dis});
    endtask

    // Waits until every expected result has come, then lets the pipeline settle.
    task automatic drain();
        wait (drive_q.size() == 0);
        repeat (25) @(negedge i_clk);
    endtask

    task automatic send_beat(logic [11:0] hd, logic [7:0] sp, logic [8:0] ef, logic [1:0] md,
                             bit typed, logic [63:0] duties, logic zn);
        t_drive e;
        @(negedge i_clk);
        // Each cycle the sender idles with the phase's probability.
        while ((idle_mode == 1 && $urandom_range(99) < 46) ||
               (idle_mode == 3 && $urandom_range(99) < 8)) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, ef, sp, hd};
        s_axis_tuser <= md;
        do @(posedge i_clk); while (!s_axis_tready);
        if (typed) begin
            e.duties = duties;
            e.zero_norm = zn;
        end else begin
            e = wheel_drive(hd, sp, ef, md);
        end
        drive_q.push_back(e);
    endtask

    task automatic send_random();
        logic [8:0] ef;
        ef = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(510) - 255);
        send_beat(12'($urandom), 8'($urandom), ef, 2'($urandom), 1'b0, '0, 1'b0);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Receiver readiness: long hold-off first, then random stalls per idling pattern.
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else if ((idle_mode == 2 && $urandom_range(99) < 46) ||
                     (idle_mode == 3 && $urandom_range(99) < 8)) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_drive e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (drive_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
            end else begin
                e = drive_q.pop_front();
                if (e.duties !== m_axis_tdata || e.zero_norm !== m_axis_tuser) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: duties exp %h got %h, zero_norm exp %b got %b",
                                 e.duties, m_axis_tdata, e.zero_norm, m_axis_tuser);
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("FAIL omni_wheel_drive_mixer");
        $finish;
    end

    t_row rows[] = '{
        // Registers at reset: every raw mix is the effort alone.
        '{0, 12'd0,    8'd0,   9'd0,             2'd0, 1, 64'h0, 1'b1},
        '{0, 12'd0,    8'd50,  9'd100,           2'd0, 1, 64'h3200_0050_0050_3200, 1'b0},
        '{0, 12'd4095, 8'd255, 9'h101,           2'd3, 1, 64'hFF00_FF00_FF00_FF00, 1'b0},
        // Omni mounting: cardinal headings, every axis mode, effort extremes.
        '{1, 12'd0,    8'd255, 9'd0,   2'd0, 0, 64'h0, 1'b0},
        '{1, 12'd1024, 8'd255, 9'd0,   2'd0, 0, 64'h0, 1'b0},
        '{1, 12'd2048, 8'd128, 9'd0,   2'd0, 0, 64'h0, 1'b0},
        '{1, 12'd3072, 8'd200, 9'd30,  2'd0, 0, 64'h0, 1'b0},
        '{1, 12'd512,  8'd255, 9'd0,   2'd1, 0, 64'h0, 1'b0},
        '{1, 12'd512,  8'd255, 9'd0,   2'd2, 0, 64'h0, 1'b0},
        '{1, 12'd1536, 8'd100, 9'h1F0, 2'd3, 0, 64'h0, 1'b0},
        '{1, 12'd4095, 8'd255, 9'd255, 2'd0, 0, 64'h0, 1'b0},
        '{1, 12'd2560, 8'd0,   9'h100, 2'd0, 0, 64'h0, 1'b0},
        '{1, 12'd3583, 8'd0,   9'h101, 2'd1, 0, 64'h0, 1'b0},
        '{1, 12'd100,  8'd255, 9'h100, 2'd2, 0, 64'h0, 1'b0},
        '{1, 12'd1024, 8'd0,   9'd0,   2'd2, 0, 64'h0, 1'b0},
        // Disabled motors still report the zero normalizer.
        '{2, 12'd0,    8'd0,   9'd0,   2'd0, 1, 64'h0, 1'b1},
        '{2, 12'd700,  8'd255, 9'd255, 2'd0, 1, 64'h0, 1'b0},
        '{2, 12'd900,  8'd20,  9'h100, 2'd3, 1, 64'h0, 1'b0}
    };

    initial begin
        int step;
        step = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            if (rows[k].step != step) begin
                stop_sending();
                drain();
                step = rows[k].step;
                if (step == 1) set_coefs(OMNI_SIN, OMNI_COS, 1'b0);
                else reg_write(ADDR_DIS, 64'd1);
            end
            send_beat(rows[k].heading, rows[k].speed, rows[k].effort, rows[k].mode,
                      rows[k].typed, rows[k].duties, rows[k].zero_norm);
        end

        for (int ph = 0; ph < 8; ph++) begin
            stop_sending();
            drain();
            case (ph)
                0: set_coefs(OMNI_SIN, OMNI_COS, 1'b0);
                1: set_coefs({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
                2: set_coefs({4{16'h8000}}, {4{16'h8000}}, 1'b0);
                3: set_coefs({4{16'h7FFF}}, {4{16'h8000}}, 1'b0);
                4: set_coefs({64{1'b1}}, 64'h0, 1'b0);
                5: set_coefs({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
                6: set_coefs({$urandom, $urandom}, 64'h0, 1'b0);
                default: set_coefs({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
            endcase
            idle_mode = ph % 4;
            // Long receiver hold-off with a steady sender fills the pipeline.
            if (ph == 0) hold_cnt = 150;
            for (int n = 0; n < 175; n++) send_random();
        end
        stop_sending();

        wait (drive_q.size() == 0);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) $display("PASS omni_wheel_drive_mixer");
        else $display("FAIL omni_wheel_drive_mixer");
        $finish;
    end
endmodule
